// ----- hw/rtl/pdta_pkg.sv -----
// Package: shared types, constants and status codes for the time accounting block.
package pdta_pkg;

  localparam int MaxProcsDef = 64;
  localparam int NumResDef   = 5;

  localparam logic [2:0] MODE_CREATE  = 3'd0;
  localparam logic [2:0] MODE_SLICE   = 3'd1;
  localparam logic [2:0] MODE_REQUEST = 3'd2;
  localparam logic [2:0] MODE_DONE    = 3'd3;
  localparam logic [2:0] MODE_EXIT    = 3'd4;
  localparam logic [2:0] MODE_ADVANCE = 3'd5;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_EXIT     = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_BADRES   = 3'd4;
  localparam logic [2:0] ST_IDLE     = 3'd5;

  localparam logic [2:0] PLACE_FREE  = 3'd0;
  localparam logic [2:0] PLACE_READY = 3'd1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] event_time;
    logic [15:0] process_id;
    logic [2:0]  resource_number;
  } pdta_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] done_id;
    logic [31:0] total_running;
    logic [31:0] total_ready;
    logic [31:0] total_blocked;
    logic [31:0] idle_total;
  } pdta_out_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan_first;
    logic scan;
    logic acct_first;
    logic acct;
    logic apply;
    logic report;
  } pdta_cmd_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ----- hw/rtl/process_dispatcher_time_accounting_top.sv -----
// Top level: dispatcher time accounting block, controller plus datapath.
//   channel | signals                 | handshake
//   input   | start, busy, in_item    | taken when start && !busy
//   result  | result_valid, result    | one cycle, no back-pressure
// An item passes a ready-head sweep and an accounting sweep of the slot table through one read
// port, then the update and the report, before the next item is accepted; result_valid is
// registered from the report state.
// After reset a clearing pass over the slot table marks every slot free; busy is high then.
// busy is high after acceptance through the report cycle and low while the result shows.
module process_dispatcher_time_accounting_top import pdta_pkg::*; #(
  parameter int MaxProcs = MaxProcsDef,
  parameter int NumRes   = NumResDef
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  pdta_in_t  in_item,
  output logic      result_valid,
  output pdta_out_t result
);

  pdta_cmd_t cmd;

  pdta_ctrl #(.MaxProcs(MaxProcs)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd)
  );

  pdta_dp #(.MaxProcs(MaxProcs), .NumRes(NumRes)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_item), .cmd(cmd),
    .result(result), .result_valid(result_valid)
  );

endmodule

// ----- hw/rtl/pdta_ctrl.sv -----
// Controller: sequences the clear pass, ready-head scan, accounting sweep, update and report.
module pdta_ctrl import pdta_pkg::*; #(
  parameter int MaxProcs = MaxProcsDef
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output pdta_cmd_t cmd
);

  localparam int IW = $clog2(MaxProcs);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_ACCT = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_REPORT = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;

  logic [2:0]    state, state_next;
  logic [IW:0]   cnt, cnt_next;
  logic          last;

  assign last = (cnt == (IW+1)'(MaxProcs + 1));

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt == (IW+1)'(MaxProcs - 1)) begin
          state_next = S_IDLE;
          cnt_next   = '0;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_HEAD;
          cnt_next   = '0;
        end
      end
      S_HEAD: begin
        // registered read: index cnt issued, data seen at count cnt is for index cnt-1
        cmd.scan_first = (cnt == (IW+1)'(1));
        cmd.scan       = (cnt != '0);
        cnt_next       = cnt + 1'b1;
        if (cnt == (IW+1)'(MaxProcs)) begin
          state_next = S_ACCT;
          cnt_next   = '0;
        end
      end
      S_ACCT: begin
        // rewind the read index first, so slot data arrives from cnt 2 on
        cmd.acct_first = (cnt == '0);
        cmd.acct       = (cnt != '0) && (cnt != (IW+1)'(1));
        cnt_next       = cnt + 1'b1;
        if (last) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_REPORT;
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- hw/rtl/pdta_dp.sv -----
// Datapath: slot memories, the oldest-entry and free-slot searches, the time charges and the result register.
module pdta_dp import pdta_pkg::*; #(
  parameter int MaxProcs = MaxProcsDef,
  parameter int NumRes   = NumResDef
) (
  input  logic      clk,
  input  logic      rst,
  input  pdta_in_t  in_item,
  input  pdta_cmd_t cmd,
  output pdta_out_t result,
  output logic      result_valid
);

  localparam int IW = $clog2(MaxProcs);

  logic [15:0] mem_pid   [MaxProcs];
  logic [31:0] mem_stamp [MaxProcs];
  logic [31:0] mem_run   [MaxProcs];
  logic [31:0] mem_wait  [MaxProcs];
  logic [31:0] mem_block [MaxProcs];
  logic [2:0]  place     [MaxProcs];

  pdta_in_t    item;
  logic [31:0] append_counter, last_time, idle_accum, delta;
  logic [IW:0] rd_cnt;
  logic [IW-1:0] rd_idx, rd_idx_q, wr_idx;

  logic [15:0] r_pid;
  logic [31:0] r_stamp, r_run, r_wait, r_block;
  logic [2:0]  r_place;

  logic          head_ok, tgt_ok, free_ok;
  logic [IW-1:0] head_idx, tgt_idx, free_idx;
  logic [31:0]   head_age, tgt_age;

  logic        bad_res, tgt_pass;
  logic [2:0]  tgt_place;
  logic [31:0] age;
  logic        is_head;

  assign bad_res = (item.resource_number == 3'd0) ||
                   (item.resource_number > 3'(NumRes));
  assign tgt_place = (item.mode == MODE_DONE) ? 3'(item.resource_number + 3'd1) : PLACE_READY;
  assign age = append_counter - r_stamp;
  assign rd_idx = rd_cnt[IW-1:0];
  assign is_head = head_ok && (rd_idx_q == head_idx);
  assign tgt_pass = (r_place == tgt_place) && (r_pid == item.process_id);

  always_ff @(posedge clk) begin
    r_pid   <= mem_pid[rd_idx];
    r_stamp <= mem_stamp[rd_idx];
    r_run   <= mem_run[rd_idx];
    r_wait  <= mem_wait[rd_idx];
    r_block <= mem_block[rd_idx];
    r_place <= place[rd_idx];
    rd_idx_q <= rd_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= '0;
    end else if (cmd.load || cmd.acct_first) begin
      rd_cnt <= '0;
    end else if (rd_cnt != (IW+1)'(MaxProcs)) begin
      rd_cnt <= rd_cnt + 1'b1;
    end
  end

  logic [31:0] w_run, w_wait, w_block;
  always_comb begin
    w_run   = r_run;
    w_wait  = r_wait;
    w_block = r_block;
    if (r_place == PLACE_READY) begin
      if (is_head) w_run = sat_add(r_run, delta);
      else         w_wait = sat_add(r_wait, delta);
    end else if (r_place != PLACE_FREE) begin
      w_block = sat_add(r_block, delta);
    end
  end

  logic        do_app, do_exit, do_create;
  logic [2:0]  app_place;
  logic [2:0]  st;
  always_comb begin
    do_app = 1'b0; do_exit = 1'b0; do_create = 1'b0;
    app_place = PLACE_READY; wr_idx = tgt_idx; st = ST_IDLE;
    case (item.mode)
      MODE_CREATE: begin
        if (free_ok) begin
          do_create = 1'b1; do_app = 1'b1; wr_idx = free_idx; st = ST_DONE;
        end else st = ST_FULL;
      end
      MODE_SLICE: begin
        if (head_ok) begin
          do_app = 1'b1; wr_idx = head_idx; st = ST_DONE;
        end else st = ST_NOTFOUND;
      end
      MODE_REQUEST, MODE_DONE: begin
        if (bad_res) st = ST_BADRES;
        else if (tgt_ok) begin
          do_app = 1'b1; st = ST_DONE;
          app_place = (item.mode == MODE_REQUEST) ?
                      3'(item.resource_number + 3'd1) : PLACE_READY;
        end else st = ST_NOTFOUND;
      end
      MODE_EXIT: begin
        if (tgt_ok) begin
          do_exit = 1'b1; st = ST_EXIT;
        end else st = ST_NOTFOUND;
      end
      default: st = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.acct) begin
      mem_run[rd_idx_q]   <= w_run;
      mem_wait[rd_idx_q]  <= w_wait;
      mem_block[rd_idx_q] <= w_block;
    end else if (cmd.apply && do_create) begin
      mem_run[wr_idx]   <= '0;
      mem_wait[wr_idx]  <= '0;
      mem_block[wr_idx] <= '0;
    end
    if (cmd.apply && do_create) mem_pid[wr_idx] <= item.process_id;
    if (cmd.apply && do_app) mem_stamp[wr_idx] <= append_counter;
    if (cmd.clear) place[rd_idx] <= PLACE_FREE;
    else if (cmd.apply && do_app) place[wr_idx] <= app_place;
    else if (cmd.apply && do_exit) place[wr_idx] <= PLACE_FREE;
    if (cmd.acct && tgt_pass && (!tgt_ok || age > tgt_age)) begin
      result.done_id       <= r_pid;
      result.total_running <= w_run;
      result.total_ready   <= w_wait;
      result.total_blocked <= w_block;
    end
    if (cmd.report) begin
      result.status     <= st;
      result.idle_total <= idle_accum;
      if (st != ST_EXIT) begin
        result.done_id <= '0; result.total_running <= '0;
        result.total_ready <= '0; result.total_blocked <= '0;
      end
    end
    if (cmd.load) item <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      append_counter <= '0;
      last_time      <= '0;
      idle_accum     <= '0;
      result_valid   <= 1'b0;
      delta <= '0;
      head_ok <= 1'b0; tgt_ok <= 1'b0; free_ok <= 1'b0;
    end else begin
      result_valid <= cmd.report;
      if (cmd.load) begin
        delta     <= (in_item.event_time >= last_time) ? in_item.event_time - last_time : '0;
        last_time <= in_item.event_time;
      end
      if (cmd.scan) begin
        if (cmd.scan_first) head_ok <= 1'b0;
        if (r_place == PLACE_READY &&
            ((cmd.scan_first ? 1'b0 : head_ok) == 1'b0 || age > head_age)) begin
          head_ok <= 1'b1; head_idx <= rd_idx_q; head_age <= age;
        end
      end
      if (cmd.acct_first) begin
        tgt_ok <= 1'b0; free_ok <= 1'b0;
        if (!head_ok) idle_accum <= sat_add(idle_accum, delta);
      end
      if (cmd.acct) begin
        if (tgt_pass && (!tgt_ok || age > tgt_age)) begin
          tgt_ok <= 1'b1; tgt_idx <= rd_idx_q; tgt_age <= age;
        end
        if (r_place == PLACE_FREE && !free_ok) begin
          free_ok <= 1'b1; free_idx <= rd_idx_q;
        end
      end
      if (cmd.apply && do_app) begin
        append_counter <= append_counter + 32'd1;
      end
    end
  end

endmodule

// ----- test/testbench.sv -----
// Testbench: random and directed dispatcher events checked against a behavioral time ledger.
module testbench import pdta_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NProc = MaxProcsDef;
  localparam int NRes  = NumResDef;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  pdta_in_t  in_item = '0;
  logic      result_valid;
  pdta_out_t result;

  process_dispatcher_time_accounting_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .result_valid(result_valid), .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [15:0] led_pid   [NProc];
  logic [2:0]  led_place [NProc];
  logic [31:0] led_stamp [NProc];
  logic [31:0] led_run   [NProc];
  logic [31:0] led_wait  [NProc];
  logic [31:0] led_block [NProc];
  logic [31:0] led_appends = '0;
  logic [31:0] led_last = '0;
  logic [31:0] led_idle = '0;

  pdta_in_t  pending_items[$];
  pdta_out_t expected_results[$];
  int        items_accepted = 0;
  int        items_total = 0;
  int        mismatches = 0;
  int        gap = 0;

  initial for (int i = 0; i < NProc; i++) led_place[i] = PLACE_FREE;

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int oldest_slot(logic [2:0] place, bit by_pid, logic [15:0] pid);
    int best;
    logic [31:0] best_age, age;
    best = -1;
    best_age = '0;
    for (int k = 0; k < NProc; k++) begin
      if (led_place[k] == place && (!by_pid || led_pid[k] == pid)) begin
        age = led_appends - led_stamp[k];
        if (best < 0 || age > best_age) begin
          best = k;
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  function automatic void enqueue_slot(int k, logic [2:0] place);
    led_place[k] = place;
    led_stamp[k] = led_appends;
    led_appends = led_appends + 32'd1;
  endfunction

  function automatic pdta_out_t ledger_step(pdta_in_t it);
    pdta_out_t r;
    logic [31:0] delta;
    int head, k;
    r = '0;
    delta = (it.event_time >= led_last) ? it.event_time - led_last : '0;
    led_last = it.event_time;
    head = oldest_slot(PLACE_READY, 0, '0);
    if (head < 0) led_idle = add_sat(led_idle, delta);
    for (int j = 0; j < NProc; j++) begin
      if (led_place[j] == PLACE_READY) begin
        if (j == head) led_run[j] = add_sat(led_run[j], delta);
        else led_wait[j] = add_sat(led_wait[j], delta);
      end else if (led_place[j] != PLACE_FREE) begin
        led_block[j] = add_sat(led_block[j], delta);
      end
    end
    case (it.mode)
      MODE_CREATE: begin
        k = oldest_slot(PLACE_FREE, 0, '0);
        if (k < 0) r.status = ST_FULL;
        else begin
          led_pid[k] = it.process_id;
          led_run[k] = '0;
          led_wait[k] = '0;
          led_block[k] = '0;
          enqueue_slot(k, PLACE_READY);
          r.status = ST_DONE;
        end
      end
      MODE_SLICE: begin
        if (head < 0) r.status = ST_NOTFOUND;
        else begin
          enqueue_slot(head, PLACE_READY);
          r.status = ST_DONE;
        end
      end
      MODE_REQUEST, MODE_DONE: begin
        if (it.resource_number < 1 || it.resource_number > NRes) r.status = ST_BADRES;
        else begin
          if (it.mode == MODE_REQUEST)
            k = oldest_slot(PLACE_READY, 1, it.process_id);
          else
            k = oldest_slot(3'(PLACE_READY + it.resource_number), 1, it.process_id);
          if (k < 0) r.status = ST_NOTFOUND;
          else begin
            enqueue_slot(k, (it.mode == MODE_REQUEST) ?
                         3'(PLACE_READY + it.resource_number) : PLACE_READY);
            r.status = ST_DONE;
          end
        end
      end
      MODE_EXIT: begin
        k = oldest_slot(PLACE_READY, 1, it.process_id);
        if (k < 0) r.status = ST_NOTFOUND;
        else begin
          r.status = ST_EXIT;
          r.done_id = led_pid[k];
          r.total_running = led_run[k];
          r.total_ready = led_wait[k];
          r.total_blocked = led_block[k];
          led_place[k] = PLACE_FREE;
        end
      end
      default: r.status = ST_IDLE;
    endcase
    r.idle_total = led_idle;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("item %0d: %s got %0h want %0h", items_accepted, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    bit launch;
    if (rst) begin
      start <= 1'b0;
      gap = 0;
    end else begin
      launch = !start;
      if (start && !busy) begin
        expected_results.push_back(ledger_step(in_item));
        items_accepted++;
        launch = 1;
      end
      if (launch) begin
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          start <= 1'b1;
          if (pending_items.size() > 60 && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 10);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    pdta_out_t w;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        report("unexpected result status", 32'(result.status), 32'd0);
      end else begin
        w = expected_results.pop_front();
        if (result.status != w.status) report("status", 32'(result.status), 32'(w.status));
        if (result.done_id != w.done_id) report("done_id", 32'(result.done_id), 32'(w.done_id));
        if (result.total_running != w.total_running)
          report("total_running", result.total_running, w.total_running);
        if (result.total_ready != w.total_ready)
          report("total_ready", result.total_ready, w.total_ready);
        if (result.total_blocked != w.total_blocked)
          report("total_blocked", result.total_blocked, w.total_blocked);
        if (result.idle_total != w.idle_total)
          report("idle_total", result.idle_total, w.idle_total);
      end
    end
  end

  logic [31:0] clock_now = '0;

  task automatic add_item(logic [2:0] m, logic [31:0] t, logic [15:0] pid, logic [2:0] res);
    pdta_in_t it;
    it.mode = m;
    it.event_time = t;
    it.process_id = pid;
    it.resource_number = res;
    pending_items.push_back(it);
    items_total++;
  endtask

  function automatic logic [31:0] next_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) clock_now = clock_now - $urandom_range(1, 1000);
    else if (r < 5) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(0, 60);
    return clock_now;
  endfunction

  function automatic logic [15:0] pick_pid();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
  endfunction

  initial begin
    int r;
    add_item(MODE_SLICE, 32'd5, 16'd0, 3'd0);
    add_item(MODE_EXIT, 32'd9, 16'd3, 3'd1);
    add_item(MODE_REQUEST, 32'd10, 16'd0, 3'd0);
    add_item(MODE_DONE, 32'd11, 16'd0, 3'd6);
    add_item(MODE_ADVANCE, 32'd12, 16'd0, 3'd0);
    add_item(3'd6, 32'd13, 16'hFFFF, 3'd7);
    add_item(3'd7, 32'd14, 16'd1, 3'd2);
    add_item(MODE_CREATE, 32'd20, 16'd0, 3'd0);
    add_item(MODE_CREATE, 32'd25, 16'hFFFF, 3'd7);
    add_item(MODE_CREATE, 32'd27, 16'hFFFF, 3'd0);
    add_item(MODE_REQUEST, 32'd30, 16'hFFFF, 3'd5);
    add_item(MODE_REQUEST, 32'd31, 16'd0, 3'd1);
    add_item(MODE_DONE, 32'd20, 16'hFFFF, 3'd5);
    add_item(MODE_DONE, 32'd40, 16'd0, 3'd2);
    add_item(MODE_SLICE, 32'd45, 16'd0, 3'd0);
    add_item(MODE_SLICE, 32'd52, 16'd0, 3'd0);
    add_item(MODE_DONE, 32'd55, 16'd0, 3'd1);
    add_item(MODE_ADVANCE, 32'hFFFF_FFF0, 16'd0, 3'd0);
    add_item(MODE_ADVANCE, 32'd0, 16'd0, 3'd0);
    add_item(MODE_ADVANCE, 32'hFFFF_FFFF, 16'd0, 3'd0);
    add_item(MODE_EXIT, 32'hFFFF_FFFF, 16'hFFFF, 3'd0);
    add_item(MODE_EXIT, 32'hFFFF_FFFF, 16'hFFFF, 3'd0);
    add_item(MODE_EXIT, 32'hFFFF_FFFF, 16'd0, 3'd0);
    add_item(MODE_EXIT, 32'hFFFF_FFFF, 16'd0, 3'd0);
    clock_now = '0;
    add_item(MODE_ADVANCE, 32'd0, 16'd0, 3'd0);
    while (items_total < 470) begin
      if (items_total > 150 && items_total < 160) begin
        for (int i = 0; i < NProc + 4; i++)
          add_item(MODE_CREATE, next_time(), pick_pid(), 3'($urandom));
        for (int i = 0; i < 40; i++)
          add_item(MODE_EXIT, next_time(), 16'($urandom_range(0, 7)), 3'd0);
      end
      r = $urandom_range(0, 99);
      if (r < 25) add_item(MODE_CREATE, next_time(), pick_pid(), 3'($urandom));
      else if (r < 40) add_item(MODE_SLICE, next_time(), pick_pid(), 3'($urandom));
      else if (r < 60)
        add_item(MODE_REQUEST, next_time(), pick_pid(),
                 ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(1, NRes)));
      else if (r < 78)
        add_item(MODE_DONE, next_time(), pick_pid(),
                 ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(1, NRes)));
      else if (r < 95) add_item(MODE_EXIT, next_time(), pick_pid(), 3'($urandom));
      else add_item(3'($urandom_range(5, 7)), next_time(), pick_pid(), 3'($urandom));
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (items_accepted == items_total);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/pdta_pkg.sv
hw/rtl/pdta_ctrl.sv
hw/rtl/pdta_dp.sv
hw/rtl/process_dispatcher_time_accounting_top.sv
test/testbench.sv
